// ----- rtl/core/rtdb_pkg.sv -----
// Package for the RSSI trimmed-mean distance block: field widths,
// register reset values, register index codes and the sequencer states.
// Used by rssi_trimmed_mean_distance_bins.sv; rtdb_ram.sv and rtdb_div.sv do not import it.
`default_nettype none

package rtdb_pkg;

   localparam int BEACON_W = 2;
   localparam int RSSI_W   = 7;
   localparam int CLASS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [RSSI_W-1:0] NEAR_RESET = 7'd70;
   localparam logic [RSSI_W-1:0] MID_RESET  = 7'd76;
   localparam logic [RSSI_W-1:0] FAR_RESET  = 7'd82;

   // Distance classes, nearest first
   localparam logic [CLASS_W-1:0] CLASS_NEAR = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_FAR  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_OUT  = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_LIMIT = 2'd0,
      CSR_MID_LIMIT  = 2'd1,
      CSR_FAR_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_TRIM,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/rtdb_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module rtdb_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 30
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/rtdb_div.sv -----
// Divider by a constant through reciprocal multiplication: quotient registered, ready in the cycle after start.
// Depends on nothing outside this file.
`default_nettype none

module rtdb_div #(
   parameter int SUM_W   = 12,
   parameter int Q_W     = 7,
   parameter int DIVISOR = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   output logic                  done,
   output logic      [Q_W-1:0]   quotient
);

   // Reciprocal rounded up; exact for every dividend below 2**SUM_W
   localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam int RECIP   = (1 << SHIFT) / DIVISOR + 1;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;

   logic [PROD_W-1:0] prod_ff;
   logic              done_ff;

   assign done     = done_ff;
   assign quotient = prod_ff[SHIFT +: Q_W];

   // Completion strobe in the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Multiply by the reciprocal and hold the product
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(dividend) * PROD_W'(RECIP);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rssi_trimmed_mean_distance_bins.sv -----
// RSSI trimmed mean with distance classes, one circular window per beacon.
// A response follows a write of the sample, a scan of the window memory through its single
// port, the trim and the registered reciprocal multiply, in that order.
// A new request is taken only in the idle state, once the previous one has moved to the
// response register, so requests never overlap. Reset: synchronous; limits return to
// 70/76/82, pointers to zero, and a pass over all BEACONS*WINDOW entries clears memory.
`default_nettype none

module rssi_trimmed_mean_distance_bins
   import rtdb_pkg::*;
#(
   parameter int WINDOW  = 10,
   parameter int BEACONS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [BEACON_W-1:0]  req_beacon,
   input  wire logic [RSSI_W-1:0]    req_rssi,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [BEACON_W-1:0]  rsp_beacon_out,
   output logic      [RSSI_W-1:0]    rsp_trimmed_mean,
   output logic      [CLASS_W-1:0]   rsp_distance_class,
   output logic                      rsp_window_wrapped,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [RSSI_W-1:0]    csr_wdata
);

   localparam int DEPTH  = BEACONS * WINDOW;
   localparam int AW     = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(WINDOW);
   localparam int BIDX_W = (BEACONS > 1) ? $clog2(BEACONS) : 1;
   localparam int SUM_W  = $clog2(WINDOW * ((1 << RSSI_W) - 1) + 1);

   state_type state_ff, state_in;

   logic [RSSI_W-1:0]   near_ff, mid_ff, far_ff;
   logic [PTR_W-1:0]    ptr_ff [0:BEACONS-1];
   logic [AW-1:0]       clr_ff;
   logic [PTR_W-1:0]    k_ff;
   logic                rd_pend_ff;
   logic [BEACON_W-1:0] beacon_ff;
   logic [BIDX_W-1:0]   bidx_ff;
   logic [AW-1:0]       base_ff;
   logic [RSSI_W-1:0]   rssi_ff;
   logic                wrap_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [RSSI_W-1:0]   min_ff, max_ff;

   logic                rsp_valid_ff;
   logic [BEACON_W-1:0] rsp_beacon_ff;
   logic [RSSI_W-1:0]   rsp_mean_ff;
   logic [CLASS_W-1:0]  rsp_class_ff;
   logic                rsp_wrap_ff;

   logic                req_take;
   logic                req_in_range;
   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic [RSSI_W-1:0]   ram_wdata;
   logic [RSSI_W-1:0]   ram_rdata;
   logic [PTR_W-1:0]    cur_ptr;
   logic                cur_wrap;
   logic [SUM_W-1:0]    trimmed;
   logic                div_done;
   logic [RSSI_W-1:0]   div_q;
   logic                rsp_room;
   logic [CLASS_W-1:0]  mean_class;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_in_range = (int'(req_beacon) < BEACONS);
   assign cur_ptr      = ptr_ff[bidx_ff];
   assign cur_wrap     = (cur_ptr == PTR_W'(WINDOW - 1));
   assign trimmed      = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
   assign rsp_room     = !rsp_valid_ff || !rsp_stall;

   rtdb_ram #(
      .WIDTH (RSSI_W),
      .DEPTH (DEPTH)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   rtdb_div #(
      .SUM_W   (SUM_W),
      .Q_W     (RSSI_W),
      .DIVISOR (WINDOW - 2)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_TRIM),
      .dividend (trimmed),
      .done     (div_done),
      .quotient (div_q)
   );

   // Classify the mean, first limit it falls below wins
   always_comb begin
      if (div_q < near_ff) begin
         mean_class = CLASS_NEAR;
      end else if (div_q < mid_ff) begin
         mean_class = CLASS_MID;
      end else if (div_q < far_ff) begin
         mean_class = CLASS_FAR;
      end else begin
         mean_class = CLASS_OUT;
      end
   end

   // Next state and memory port control
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_addr  = clr_ff;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && req_in_range) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_addr  = base_ff + AW'(cur_ptr);
            ram_wdata = rssi_ff;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            ram_addr = base_ff + AW'(k_ff);
            if (k_ff == PTR_W'(WINDOW - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_room) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         near_ff      <= NEAR_RESET;
         mid_ff       <= MID_RESET;
         far_ff       <= FAR_RESET;
         for (int i = 0; i < BEACONS; i++) begin
            ptr_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SCAN);

         // Sweep the memory after reset
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end

         // Advance the scan index
         if (state_ff == ST_SCAN) begin
            k_ff <= k_ff + PTR_W'(1);
         end else begin
            k_ff <= '0;
         end

         // Advance the beacon's write pointer, wrap at the window length
         if (state_ff == ST_WRITE) begin
            ptr_ff[bidx_ff] <= cur_wrap ? '0 : cur_ptr + PTR_W'(1);
         end

         // Hold or drop the response
         if (state_ff == ST_FINISH && rsp_room) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Limit registers
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NEAR_LIMIT: near_ff <= csr_wdata;
               CSR_MID_LIMIT:  mid_ff  <= csr_wdata;
               CSR_FAR_LIMIT:  far_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath: latch the request, accumulate sum, minimum and maximum, load the response
   always_ff @(posedge clock) begin
      if (req_take) begin
         beacon_ff <= req_beacon;
         bidx_ff   <= BIDX_W'(req_beacon);
         base_ff   <= AW'(int'(req_beacon) * WINDOW);
         rssi_ff   <= req_rssi;
      end
      if (state_ff == ST_WRITE) begin
         wrap_ff <= cur_wrap;
         sum_ff  <= '0;
         min_ff  <= '1;
         max_ff  <= '0;
      end else if (rd_pend_ff) begin
         sum_ff <= sum_ff + SUM_W'(ram_rdata);
         if (ram_rdata < min_ff) begin
            min_ff <= ram_rdata;
         end
         if (ram_rdata > max_ff) begin
            max_ff <= ram_rdata;
         end
      end
      if (state_ff == ST_FINISH && rsp_room) begin
         rsp_beacon_ff <= beacon_ff;
         rsp_mean_ff   <= div_q;
         rsp_class_ff  <= mean_class;
         rsp_wrap_ff   <= wrap_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_beacon_out     = rsp_beacon_ff;
   assign rsp_trimmed_mean   = rsp_mean_ff;
   assign rsp_distance_class = rsp_class_ff;
   assign rsp_window_wrapped = rsp_wrap_ff;

endmodule

`default_nettype wire
